// File: design/rcfd_pkg.sv
package rcfd_pkg;

    // Frame geometry
    localparam int FRAME_BYTES  = 18;
    localparam int COUNT_W      = $clog2(FRAME_BYTES + 2);
    localparam int QUEUE_DEPTH  = 2;

    // Wheel offset (sticks use the same offset through center11)
    localparam logic [15:0] CHANNEL_OFFSET = 16'd1024;

    // Input beat kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_FRAME_END = 2'd1;
    localparam logic [1:0] KIND_TICK      = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_BAD_LEN   = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_OFFLINE   = 2'd3;

    // Queue operations
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic REG_CHANNEL_LIMIT = 1'b0;
    localparam logic REG_OFFLINE_TICKS = 1'b1;

    localparam logic [10:0] CHANNEL_LIMIT_RESET = 11'd660;
    localparam logic [15:0] OFFLINE_TICKS_RESET = 16'd100;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic signed [10:0] ch_a;
        logic signed [10:0] ch_b;
        logic signed [10:0] ch_c;
        logic signed [10:0] ch_d;
        logic signed [11:0] wheel;
        logic        [3:0]  switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic        [1:0]  buttons;
        logic        [15:0] keys;
    } t_record;

    typedef struct packed {
        logic        op;
        logic [1:0]  status;
        t_record     rec;
    } t_cmd;

    typedef struct packed {
        logic [10:0] channel_limit;
        logic [15:0] offline_ticks;
    } t_cfg;

    // True when v lies within +-lim
    function automatic logic in_limit(input logic signed [15:0] v, input logic [10:0] lim);
        logic signed [16:0] v_s;
        logic signed [16:0] lim_s;
        v_s   = 17'(v);
        lim_s = signed'({6'b0, lim});
        return (v_s <= lim_s) && (v_s >= -lim_s);
    endfunction

    // Offset-binary 11-bit raw value to centered signed value
    function automatic logic signed [10:0] center11(input logic [10:0] raw);
        return signed'({~raw[10], raw[9:0]});
    endfunction

endpackage

// File: design/rcfd_front.sv
module rcfd_front
    import rcfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data,
    input  t_cfg        i_cfg,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_byte              r_frame [FRAME_BYTES];

    logic        accept;
    logic [15:0] wheel16;
    t_record     dec;
    logic        range_ok;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Byte collection; drop bytes past the frame and pin the count past it
    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_kind == KIND_BYTE) begin
                if (r_count < COUNT_W'(FRAME_BYTES)) begin
                    n_count = r_count + COUNT_W'(1);
                end else begin
                    n_count = COUNT_W'(FRAME_BYTES + 1);
                end
            end else if (i_kind == KIND_FRAME_END) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_BYTE && r_count < COUNT_W'(FRAME_BYTES)) begin
            r_frame[r_count[COUNT_W-1:0]] <= i_data;
        end
    end

    // Unpack the buffered frame
    always_comb begin
        wheel16      = {r_frame[17], r_frame[16]} - CHANNEL_OFFSET;
        dec.ch_a     = center11({r_frame[1][2:0], r_frame[0]});
        dec.ch_b     = center11({r_frame[2][5:0], r_frame[1][7:3]});
        dec.ch_c     = center11({r_frame[4][0], r_frame[3], r_frame[2][7:6]});
        dec.ch_d     = center11({r_frame[5][3:0], r_frame[4][7:1]});
        dec.wheel    = signed'(wheel16[11:0]);
        dec.switches = r_frame[5][7:4];
        dec.mouse_x  = signed'({r_frame[7], r_frame[6]});
        dec.mouse_y  = signed'({r_frame[9], r_frame[8]});
        dec.mouse_z  = signed'({r_frame[11], r_frame[10]});
        dec.buttons  = {r_frame[13][0], r_frame[12][0]};
        dec.keys     = {r_frame[15], r_frame[14]};

        range_ok = in_limit(16'(dec.ch_a), i_cfg.channel_limit)
                && in_limit(16'(dec.ch_b), i_cfg.channel_limit)
                && in_limit(16'(dec.ch_c), i_cfg.channel_limit)
                && in_limit(16'(dec.ch_d), i_cfg.channel_limit)
                && in_limit(signed'(wheel16), i_cfg.channel_limit)
                && (dec.switches[3:2] != 2'b00)
                && (dec.switches[1:0] != 2'b00)
                && (r_frame[12] <= 8'd1)
                && (r_frame[13] <= 8'd1);
    end

    // Classify frame ends and ticks into queue commands
    always_comb begin
        o_push     = accept && (i_kind == KIND_FRAME_END || i_kind == KIND_TICK);
        o_cmd.op   = (i_kind == KIND_TICK) ? OP_TICK : OP_FRAME;
        o_cmd.rec  = dec;
        if (r_count != COUNT_W'(FRAME_BYTES)) begin
            o_cmd.status = ST_BAD_LEN;
        end else if (!range_ok) begin
            o_cmd.status = ST_RANGE;
        end else begin
            o_cmd.status = ST_ACCEPTED;
        end
    end

endmodule

// File: design/rcfd_queue.sv
module rcfd_queue
    import rcfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_cmd  o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// File: design/rcfd_back.sv
module rcfd_back
    import rcfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_record     o_rec,
    output logic [1:0]  o_status
);

    t_record     r_rec;
    t_record     n_rec;
    logic        r_online;
    logic        n_online;
    logic [15:0] r_idle;
    logic [15:0] n_idle;
    logic        r_out_valid;
    logic        n_out_valid;
    t_record     r_out_rec;
    t_record     n_out_rec;
    logic [1:0]  r_out_status;
    logic [1:0]  n_out_status;

    // Pop when the output slot is free or drains this cycle
    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    always_comb begin
        n_rec        = r_rec;
        n_online     = r_online;
        n_idle       = r_idle;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_rec    = r_out_rec;
        n_out_status = r_out_status;
        if (o_pop) begin
            if (i_cmd.op == OP_FRAME) begin
                if (i_cmd.status == ST_ACCEPTED) begin
                    n_rec    = i_cmd.rec;
                    n_online = 1'b1;
                    n_idle   = '0;
                end
                n_out_valid  = 1'b1;
                n_out_rec    = (i_cmd.status == ST_ACCEPTED) ? i_cmd.rec : r_rec;
                n_out_status = i_cmd.status;
            end else if (r_online) begin
                if (r_idle >= i_cfg.offline_ticks) begin
                    n_rec        = '0;
                    n_online     = 1'b0;
                    n_idle       = '0;
                    n_out_valid  = 1'b1;
                    n_out_rec    = '0;
                    n_out_status = ST_OFFLINE;
                end else begin
                    n_idle = r_idle + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec       <= '0;
            r_online    <= 1'b0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rec       <= n_rec;
            r_online    <= n_online;
            r_idle      <= n_idle;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rec    <= n_out_rec;
        r_out_status <= n_out_status;
    end

    assign o_valid  = r_out_valid;
    assign o_rec    = r_out_rec;
    assign o_status = r_out_status;

endmodule

// File: design/rc_receiver_frame_decoder.sv
// Channel   Direction  Beat contents
// s_axis    in         tuser[1:0] kind; tdata[7:0] data_byte
// m_axis    out        tuser[1:0] status; tdata[125:0] held record (see port)
// apb       in/out     0x0 channel_limit[10:0], 0x4 offline_ticks[15:0]
//
// One input beat is taken every cycle while the command queue has room.
// A frame end passes the command queue and then the result register; a tick gives a
// result only on going offline. One queued command drains per cycle unless m_axis stalls.
// Reset (synchronous, active low) clears the byte count, held record, link state,
// queue and output valid; configuration returns to 660 and 100.
// A stalled output holds the result; the queue then fills and s_axis tready drops.
module rc_receiver_frame_decoder
    import rcfd_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input beats
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]   i_s_axis_tuser,   // [1:0] kind
    // result beats
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [10:0] channel_a, [21:11] channel_b, [32:22] channel_c, [43:33] channel_d,
    // [55:44] wheel_value, [59:56] switches, [75:60] mouse_x, [91:76] mouse_y,
    // [107:92] mouse_z, [109:108] mouse_buttons, [125:110] key_mask, [127:126] zero
    output logic [127:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser,   // [1:0] status
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_cfg        r_cfg;
    t_cmd        front_cmd;
    t_cmd        queue_cmd;
    logic        push;
    logic        q_full;
    logic        q_valid;
    logic        pop;
    t_record     out_rec;
    logic [1:0]  out_status;
    logic        reg_sel;

    // Configuration: register index is the word address
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_limit <= CHANNEL_LIMIT_RESET;
            r_cfg.offline_ticks <= OFFLINE_TICKS_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_CHANNEL_LIMIT: r_cfg.channel_limit <= pwdata[10:0];
                REG_OFFLINE_TICKS: r_cfg.offline_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_CHANNEL_LIMIT: prdata = {21'b0, r_cfg.channel_limit};
            REG_OFFLINE_TICKS: prdata = {16'b0, r_cfg.offline_ticks};
            default:           prdata = '0;
        endcase
    end

    // Front: collect bytes, decode and check frames, queue frame ends and ticks
    rcfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_kind   (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    rcfd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (queue_cmd)
    );

    // Back: hold the record, age the link, register results
    rcfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_cmd     (queue_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_rec     (out_rec),
        .o_status  (out_status)
    );

    assign o_m_axis_tdata = {2'b00,
                             out_rec.keys,
                             out_rec.buttons,
                             out_rec.mouse_z,
                             out_rec.mouse_y,
                             out_rec.mouse_x,
                             out_rec.switches,
                             out_rec.wheel,
                             out_rec.ch_d,
                             out_rec.ch_c,
                             out_rec.ch_b,
                             out_rec.ch_a};
    assign o_m_axis_tuser = out_status;

endmodule
